FILE: design/dual_pid_arm_hold_controller_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the dual PID arm hold controller
// Shared property wrappers, clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef DUAL_PID_ARM_HOLD_CONTROLLER_MACROS_SVH
`define DUAL_PID_ARM_HOLD_CONTROLLER_MACROS_SVH

// Same-cycle implication: antecedent holds, consequent holds in that cycle
`define DPAH_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: antecedent holds, consequent holds in the next cycle
`define DPAH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/dpah_pkg.sv
// ---------------------------------------------------------------------------
// dpah_pkg
// Widths, register indexes, command codes and types of the arm controller.
// ---------------------------------------------------------------------------
package dpah_pkg;

  // Sizing of the datapath
  localparam int SENSOR_BITS    = 12;
  localparam int INTEGRAL_BITS  = 20;
  localparam int GAIN_FRAC_BITS = 12;
  localparam int DRIVE_LIMIT    = 127;

  // Fixed field widths
  localparam int DRIVE_W    = 8;
  localparam int STICK_W    = 8;
  localparam int FUNC_W     = 2;
  localparam int GAIN_W     = 16;
  localparam int ZONE_W     = 12;
  localparam int DBAND_W    = 7;
  localparam int OFFSET_W   = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Derived datapath widths
  localparam int ERR_W   = SENSOR_BITS + 1;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int ISUM_W  = ((INTEGRAL_BITS > ERR_W) ? INTEGRAL_BITS : ERR_W) + 1;
  localparam int SKEW_W  = ((ERR_W > OFFSET_W) ? ERR_W : OFFSET_W) + 1;
  localparam int PD_W    = DIFF_W + GAIN_W;
  localparam int PI_W    = INTEGRAL_BITS + GAIN_W;
  localparam int PP_W    = ERR_W + GAIN_W;
  localparam int PT_W    = SKEW_W + GAIN_W;
  localparam int SUM_W   = ((PI_W > PD_W) ? PI_W : PD_W) + 2;
  localparam int BASE_W  = DRIVE_W + 1 + GAIN_FRAC_BITS + 1;
  localparam int FULL_W  = ((PT_W > BASE_W) ? PT_W : BASE_W) + 1;
  localparam int WIDE_W  = (SUM_W > FULL_W) ? SUM_W : FULL_W;

  // Register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_PROP_GAIN      = 3'd0;
  localparam cfg_idx_t CFG_INTEG_GAIN     = 3'd1;
  localparam cfg_idx_t CFG_DERIV_GAIN     = 3'd2;
  localparam cfg_idx_t CFG_INTEGRAL_ZONE  = 3'd3;
  localparam cfg_idx_t CFG_STICK_DEADBAND = 3'd4;
  localparam cfg_idx_t CFG_SKEW_GAIN      = 3'd5;
  localparam cfg_idx_t CFG_SKEW_OFFSET    = 3'd6;

  // Command codes
  typedef logic [FUNC_W-1:0] func_t;
  localparam func_t FUNC_HOLD      = 2'd0;
  localparam func_t FUNC_FULL_UP   = 2'd1;
  localparam func_t FUNC_FULL_DOWN = 2'd2;

  // One captured request
  typedef struct packed {
    logic [SENSOR_BITS-1:0]    left_raw;
    logic [SENSOR_BITS-1:0]    right_raw;
    func_t                     func;
    logic signed [STICK_W-1:0] stick_value;
  } in_item_t;

endpackage

FILE: design/dual_pid_arm_hold_controller.sv
// Flow: an accepted request lands in the input register (stage 1); one compute
//   pass loads the output register once the output slot is free or draining.
// Throughput: one request per cycle when not stalled; the PID state loop closes in
//   the single compute pass, so back-to-back requests see the updated integral and target.
// Reset (synchronous, rst_n low): empties both stages, loads register defaults,
//   clears integrals and previous errors; the first request captures the targets.
// ---------------------------------------------------------------------------
// dual_pid_arm_hold_controller
// Two-sided arm hold controller: PID per side with integral zone, full-speed
// commands with skew correction, and joystick override.
// ---------------------------------------------------------------------------
module dual_pid_arm_hold_controller (
  input  logic                                      clk,
  input  logic                                      rst_n,
  // request channel
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [dpah_pkg::SENSOR_BITS-1:0]          in_left_raw,
  input  logic [dpah_pkg::SENSOR_BITS-1:0]          in_right_raw,
  input  logic [dpah_pkg::FUNC_W-1:0]               in_func,
  input  logic signed [dpah_pkg::STICK_W-1:0]       in_stick_value,
  // result channel
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic signed [dpah_pkg::DRIVE_W-1:0]       out_left_drive,
  output logic signed [dpah_pkg::DRIVE_W-1:0]       out_right_drive,
  output logic                                      out_manual_active,
  // configuration
  input  logic                                      cfg_we,
  input  logic [dpah_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [dpah_pkg::CFG_DATA_W-1:0]           cfg_wdata
);

  localparam int SB = dpah_pkg::SENSOR_BITS;
  localparam int IW = dpah_pkg::INTEGRAL_BITS;
  localparam int EW = dpah_pkg::ERR_W;
  localparam int WW = dpah_pkg::WIDE_W;
  localparam int DW = dpah_pkg::DRIVE_W;
  localparam int FB = dpah_pkg::GAIN_FRAC_BITS;

  localparam logic signed [WW-1:0] LIMIT_POS = WW'(dpah_pkg::DRIVE_LIMIT);
  localparam logic signed [WW-1:0] LIMIT_NEG = -WW'(dpah_pkg::DRIVE_LIMIT);
  localparam logic signed [WW-1:0] ROUND_ADJ = WW'((2 ** FB) - 1);
  localparam logic signed [WW-1:0] FULL_BASE =
    WW'(dpah_pkg::DRIVE_LIMIT * (2 ** FB));
  localparam logic signed [dpah_pkg::ISUM_W-1:0] IMAX =
    dpah_pkg::ISUM_W'((2 ** (IW - 1)) - 1);
  localparam logic signed [dpah_pkg::ISUM_W-1:0] IMIN = -IMAX - 1;

  // Clamp a wide value to the drive range
  function automatic logic signed [DW-1:0] sat_drive(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] c;
    c = v;
    if (v > LIMIT_POS) c = LIMIT_POS;
    if (v < LIMIT_NEG) c = LIMIT_NEG;
    return c[DW-1:0];
  endfunction

  // Drop the fraction toward zero, then clamp
  function automatic logic signed [DW-1:0] scale_sat(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] adj;
    adj = (v < 0) ? (v + ROUND_ADJ) : v;
    return sat_drive(adj >>> FB);
  endfunction

  // Accumulate inside the zone with saturation, clear outside it
  function automatic logic signed [IW-1:0] integ_next(
    input logic signed [IW-1:0]               integ,
    input logic signed [EW-1:0]               err,
    input logic [dpah_pkg::ZONE_W-1:0]        zone
  );
    logic [EW-1:0]                      mag;
    logic signed [dpah_pkg::ISUM_W-1:0] s;
    mag = (err < 0) ? EW'(-err) : EW'(err);
    s   = dpah_pkg::ISUM_W'(integ) + dpah_pkg::ISUM_W'(err);
    if (s > IMAX) s = IMAX;
    if (s < IMIN) s = IMIN;
    if (mag < zone) return s[IW-1:0];
    return '0;
  endfunction

  // Weighted sum of the three PID terms, scaled and clamped
  function automatic logic signed [DW-1:0] pid_drive(
    input logic signed [EW-1:0]              err,
    input logic signed [EW-1:0]              prev,
    input logic signed [IW-1:0]              integ,
    input logic signed [dpah_pkg::GAIN_W-1:0] kp,
    input logic signed [dpah_pkg::GAIN_W-1:0] ki,
    input logic signed [dpah_pkg::GAIN_W-1:0] kd
  );
    logic signed [dpah_pkg::DIFF_W-1:0] d;
    logic signed [dpah_pkg::PD_W-1:0]   pd;
    logic signed [dpah_pkg::PI_W-1:0]   pi;
    logic signed [dpah_pkg::PP_W-1:0]   pp;
    logic signed [WW-1:0]               sum;
    d   = dpah_pkg::DIFF_W'(err) - dpah_pkg::DIFF_W'(prev);
    pd  = d * kd;
    pi  = integ * ki;
    pp  = err * kp;
    sum = WW'(pd) + WW'(pi) + WW'(pp);
    return scale_sat(sum);
  endfunction

  // Configuration registers
  logic signed [dpah_pkg::GAIN_W-1:0]   prop_gain_r, integ_gain_r, deriv_gain_r, skew_gain_r;
  logic [dpah_pkg::ZONE_W-1:0]          integral_zone_r;
  logic [dpah_pkg::DBAND_W-1:0]         stick_deadband_r;
  logic signed [dpah_pkg::OFFSET_W-1:0] skew_offset_r;

  // Controller state
  logic [SB-1:0]        target_left_r, target_right_r, target_left_nxt, target_right_nxt;
  logic signed [IW-1:0] integral_left_r, integral_right_r;
  logic signed [IW-1:0] integral_left_nxt, integral_right_nxt;
  logic signed [EW-1:0] prev_error_left_r, prev_error_right_r;
  logic                 started_r;

  // Pipeline registers
  logic                  s1_valid_r;
  dpah_pkg::in_item_t    s1_item_r;
  logic                  out_valid_r;
  logic signed [DW-1:0]  out_left_r, out_right_r, out_left_nxt, out_right_nxt;
  logic                  out_manual_r, out_manual_nxt;

  // Compute pass signals
  logic                 advance;
  logic [SB-1:0]        pos_l, pos_r, tgt_l, tgt_r;
  logic signed [EW-1:0] err_l, err_r, diff_rl;
  logic signed [dpah_pkg::SKEW_W-1:0] skew;
  logic signed [dpah_pkg::PT_W-1:0]   skew_t;
  logic signed [DW-1:0] pid_l, pid_r;
  logic signed [dpah_pkg::STICK_W:0]  stick_ext, dband_ext;
  logic                 stick_on;

  // Handshake: stage 1 moves on whenever the output slot is free or draining
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;

  assign out_valid         = out_valid_r;
  assign out_left_drive    = out_left_r;
  assign out_right_drive   = out_right_r;
  assign out_manual_active = out_manual_r;

  // Form positions, errors and the integral update
  always_comb begin
    pos_l = ~s1_item_r.left_raw;
    pos_r = s1_item_r.right_raw;
    tgt_l = started_r ? target_left_r  : pos_l;
    tgt_r = started_r ? target_right_r : pos_r;
    err_l = $signed({1'b0, tgt_l}) - $signed({1'b0, pos_l});
    err_r = $signed({1'b0, tgt_r}) - $signed({1'b0, pos_r});
    integral_left_nxt  = integ_next(integral_left_r,  err_l, integral_zone_r);
    integral_right_nxt = integ_next(integral_right_r, err_r, integral_zone_r);
    pid_l = pid_drive(err_l, prev_error_left_r, integral_left_nxt,
                      prop_gain_r, integ_gain_r, deriv_gain_r);
    pid_r = pid_drive(err_r, prev_error_right_r, integral_right_nxt,
                      prop_gain_r, integ_gain_r, deriv_gain_r);
  end

  // Skew term and joystick test
  always_comb begin
    diff_rl   = $signed({1'b0, pos_r}) - $signed({1'b0, pos_l});
    skew      = dpah_pkg::SKEW_W'(diff_rl) + dpah_pkg::SKEW_W'(skew_offset_r);
    skew_t    = skew * skew_gain_r;
    stick_ext = (dpah_pkg::STICK_W + 1)'(s1_item_r.stick_value);
    dband_ext = $signed({2'b00, stick_deadband_r});
    stick_on  = (stick_ext > dband_ext) || (stick_ext < -dband_ext);
  end

  // Select the drive by command priority
  always_comb begin
    out_manual_nxt = 1'b1;
    case (s1_item_r.func)
      dpah_pkg::FUNC_FULL_UP: begin
        out_left_nxt  = scale_sat(FULL_BASE + WW'(skew_t));
        out_right_nxt = scale_sat(FULL_BASE - WW'(skew_t));
      end
      dpah_pkg::FUNC_FULL_DOWN: begin
        out_left_nxt  = scale_sat(-FULL_BASE - WW'(skew_t));
        out_right_nxt = scale_sat(-FULL_BASE + WW'(skew_t));
      end
      default: begin
        if (stick_on) begin
          out_left_nxt  = sat_drive(WW'(s1_item_r.stick_value));
          out_right_nxt = sat_drive(WW'(s1_item_r.stick_value));
        end else begin
          out_left_nxt   = pid_l;
          out_right_nxt  = pid_r;
          out_manual_nxt = 1'b0;
        end
      end
    endcase
    target_left_nxt  = out_manual_nxt ? pos_l : tgt_l;
    target_right_nxt = out_manual_nxt ? pos_r : tgt_r;
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r      <= 16'sd614;
      integ_gain_r     <= '0;
      deriv_gain_r     <= '0;
      integral_zone_r  <= 12'd100;
      stick_deadband_r <= 7'd30;
      skew_gain_r      <= '0;
      skew_offset_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dpah_pkg::CFG_PROP_GAIN:      prop_gain_r      <= cfg_wdata;
        dpah_pkg::CFG_INTEG_GAIN:     integ_gain_r     <= cfg_wdata;
        dpah_pkg::CFG_DERIV_GAIN:     deriv_gain_r     <= cfg_wdata;
        dpah_pkg::CFG_INTEGRAL_ZONE:  integral_zone_r  <= cfg_wdata[dpah_pkg::ZONE_W-1:0];
        dpah_pkg::CFG_STICK_DEADBAND: stick_deadband_r <= cfg_wdata[dpah_pkg::DBAND_W-1:0];
        dpah_pkg::CFG_SKEW_GAIN:      skew_gain_r      <= cfg_wdata;
        dpah_pkg::CFG_SKEW_OFFSET:    skew_offset_r    <= cfg_wdata[dpah_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the request into stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.left_raw    <= in_left_raw;
      s1_item_r.right_raw   <= in_right_raw;
      s1_item_r.func        <= in_func;
      s1_item_r.stick_value <= in_stick_value;
    end
  end

  // Advance stage 1 into the output register and update the PID state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r        <= 1'b0;
      started_r          <= 1'b0;
      integral_left_r    <= '0;
      integral_right_r   <= '0;
      prev_error_left_r  <= '0;
      prev_error_right_r <= '0;
      target_left_r      <= '0;
      target_right_r     <= '0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        started_r          <= 1'b1;
        integral_left_r    <= integral_left_nxt;
        integral_right_r   <= integral_right_nxt;
        prev_error_left_r  <= err_l;
        prev_error_right_r <= err_r;
        target_left_r      <= target_left_nxt;
        target_right_r     <= target_right_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_left_r   <= out_left_nxt;
      out_right_r  <= out_right_nxt;
      out_manual_r <= out_manual_nxt;
    end
  end

endmodule

FILE: design/dpah_checker.sv
// ---------------------------------------------------------------------------
// dpah_checker
// Port-level checks on the arm controller, bound to the top level.
// ---------------------------------------------------------------------------
`include "dual_pid_arm_hold_controller_macros.svh"

module dpah_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [dpah_pkg::DRIVE_W-1:0] out_left_drive,
  input logic signed [dpah_pkg::DRIVE_W-1:0] out_right_drive,
  input logic                                out_manual_active
);

  // Hold a stalled result steady
  `DPAH_ASSERT_NEXT(a_out_stall_hold, out_valid && !out_ready,
    out_valid && $stable(out_left_drive) && $stable(out_right_drive)
      && $stable(out_manual_active),
    "stalled result changed")

  // Accept requests whenever the output slot is empty
  `DPAH_ASSERT_IMPLY(a_ready_when_empty, !out_valid, in_ready,
    "request blocked with empty output")

  // Drop no request: an accepted request passes stage 1 into the output register if not stalled
  `DPAH_ASSERT_NEXT(a_two_cycle_latency, (in_valid && in_ready) ##1 out_ready, out_valid,
    "accepted request did not reach the output")

  // Keep drives inside the symmetric saturation range
  `DPAH_ASSERT_IMPLY(a_drive_range, out_valid,
    (out_left_drive != 8'h80) && (out_right_drive != 8'h80),
    "drive outside saturation range")

endmodule

bind dual_pid_arm_hold_controller dpah_checker u_dpah_checker (.*);

FILE: tb/dual_pid_arm_hold_controller_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dual PID arm hold controller testbench
// Drives control ticks through the request channel, predicts every drive
// result with an independent model of the hold, full-speed and joystick
// paths, and compares results field by field across several register
// settings, idling patterns and a long result-side stall.
// ----------------------------------------------------------------------------
module dual_pid_arm_hold_controller_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 265;
  localparam int PHASE_COUNT = 6;
  localparam int LONG_STALL  = 200;
  localparam dpah_pkg::func_t FUNC_UNUSED = 2'd3;

  localparam longint FRAC_ONE   = longint'(1) << dpah_pkg::GAIN_FRAC_BITS;
  localparam longint FULL_BASE  = longint'(dpah_pkg::DRIVE_LIMIT) * FRAC_ONE;
  localparam longint SENSOR_MAX = (longint'(1) << dpah_pkg::SENSOR_BITS) - 1;
  localparam longint INTEG_MAX  = (longint'(1) << (dpah_pkg::INTEGRAL_BITS - 1)) - 1;
  localparam longint INTEG_MIN  = -INTEG_MAX - 1;

  typedef struct packed {
    logic signed [dpah_pkg::DRIVE_W-1:0] left_drive;
    logic signed [dpah_pkg::DRIVE_W-1:0] right_drive;
    logic                                manual_active;
  } drive_result_t;

  typedef struct packed {
    dpah_pkg::in_item_t req;
    logic               has_fixed;
    drive_result_t      fixed_res;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [dpah_pkg::SENSOR_BITS-1:0] in_left_raw;
  logic [dpah_pkg::SENSOR_BITS-1:0] in_right_raw;
  logic [dpah_pkg::FUNC_W-1:0] in_func;
  logic signed [dpah_pkg::STICK_W-1:0] in_stick_value;
  logic out_valid;
  logic out_ready;
  logic signed [dpah_pkg::DRIVE_W-1:0] out_left_drive;
  logic signed [dpah_pkg::DRIVE_W-1:0] out_right_drive;
  logic out_manual_active;
  logic cfg_we;
  logic [dpah_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [dpah_pkg::CFG_DATA_W-1:0] cfg_wdata;

  dual_pid_arm_hold_controller uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_left_raw       (in_left_raw),
    .in_right_raw      (in_right_raw),
    .in_func           (in_func),
    .in_stick_value    (in_stick_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_left_drive    (out_left_drive),
    .out_right_drive   (out_right_drive),
    .out_manual_active (out_manual_active),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Register shadows, reset values
  logic signed [dpah_pkg::GAIN_W-1:0]   kp_gain  = 16'sd614;
  logic signed [dpah_pkg::GAIN_W-1:0]   ki_gain  = '0;
  logic signed [dpah_pkg::GAIN_W-1:0]   kd_gain  = '0;
  logic [dpah_pkg::ZONE_W-1:0]          izone    = 12'd100;
  logic [dpah_pkg::DBAND_W-1:0]         deadband = 7'd30;
  logic signed [dpah_pkg::GAIN_W-1:0]   skew_k   = '0;
  logic signed [dpah_pkg::OFFSET_W-1:0] skew_ofs = '0;

  // Controller state as the predictor sees it
  logic [dpah_pkg::SENSOR_BITS-1:0]          hold_target_l = '0;
  logic [dpah_pkg::SENSOR_BITS-1:0]          hold_target_r = '0;
  logic signed [dpah_pkg::INTEGRAL_BITS-1:0] integ_sum_l   = '0;
  logic signed [dpah_pkg::INTEGRAL_BITS-1:0] integ_sum_r   = '0;
  logic signed [dpah_pkg::ERR_W-1:0]         last_err_l    = '0;
  logic signed [dpah_pkg::ERR_W-1:0]         last_err_r    = '0;
  logic                                      targets_captured = 1'b0;

  drive_result_t expected_drives [$];
  int mismatches = 0;
  int sent_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit stall_request = 1'b0;
  int stall_left = 0;
  int unsigned cycle_count = 0;
  int cur_l_raw = 2048;
  int cur_r_raw = 2048;

  // Directed ticks, all under reset register values
  directed_row_t directed_rows [16] = '{
    // first tick captures the targets: zero error
    '{'{12'd0, 12'd4095, dpah_pkg::FUNC_HOLD, 8'sd0}, 1'b1, '{8'sd0, 8'sd0, 1'b0}},
    // full-scale error saturates the PID
    '{'{12'd4095, 12'd0, dpah_pkg::FUNC_HOLD, 8'sd0}, 1'b1, '{8'sd127, 8'sd127, 1'b0}},
    '{'{12'd0, 12'd0, dpah_pkg::FUNC_FULL_UP, 8'sd0}, 1'b1, '{8'sd127, 8'sd127, 1'b1}},
    // full down wins over a loud stick
    '{'{12'd4095, 12'd4095, dpah_pkg::FUNC_FULL_DOWN, 8'sd127}, 1'b1,
      '{-8'sd127, -8'sd127, 1'b1}},
    '{'{12'd2047, 12'd2048, dpah_pkg::FUNC_HOLD, 8'sd127}, 1'b1, '{8'sd127, 8'sd127, 1'b1}},
    // most negative stick clips to the drive limit
    '{'{12'd2047, 12'd2048, dpah_pkg::FUNC_HOLD, 8'h80}, 1'b1, '{-8'sd127, -8'sd127, 1'b1}},
    '{'{12'd2047, 12'd2048, dpah_pkg::FUNC_HOLD, 8'sd31}, 1'b1, '{8'sd31, 8'sd31, 1'b1}},
    // stick on the deadband edge falls back to PID
    '{'{12'd2047, 12'd2048, dpah_pkg::FUNC_HOLD, 8'sd30}, 1'b1, '{8'sd0, 8'sd0, 1'b0}},
    '{'{12'd2047, 12'd2048, dpah_pkg::FUNC_HOLD, -8'sd31}, 1'b1, '{-8'sd31, -8'sd31, 1'b1}},
    // unused command acts as hold
    '{'{12'd2047, 12'd2048, FUNC_UNUSED, -8'sd30}, 1'b1, '{8'sd0, 8'sd0, 1'b0}},
    '{'{12'd2047, 12'd2048, FUNC_UNUSED, 8'sd100}, 1'b1, '{8'sd100, 8'sd100, 1'b1}},
    '{'{12'd1997, 12'd2100, dpah_pkg::FUNC_HOLD, 8'sd5}, 1'b0, '0},
    // error magnitude equal to the zone clears the integral
    '{'{12'd2147, 12'd1990, dpah_pkg::FUNC_HOLD, -8'sd7}, 1'b0, '0},
    '{'{12'd0, 12'd4095, dpah_pkg::FUNC_HOLD, 8'sd0}, 1'b1, '{-8'sd127, -8'sd127, 1'b0}},
    '{'{12'd4095, 12'd4095, dpah_pkg::FUNC_FULL_UP, 8'sd0}, 1'b1, '{8'sd127, 8'sd127, 1'b1}},
    '{'{12'd4095, 12'd4095, dpah_pkg::FUNC_HOLD, 8'sd0}, 1'b1, '{8'sd0, 8'sd0, 1'b0}}
  };

  function automatic longint clamp_drive(input longint v);
    if (v > dpah_pkg::DRIVE_LIMIT) return longint'(dpah_pkg::DRIVE_LIMIT);
    if (v < -dpah_pkg::DRIVE_LIMIT) return -longint'(dpah_pkg::DRIVE_LIMIT);
    return v;
  endfunction

  // Drop the fraction (toward zero), then clip
  function automatic longint scale_drive(input longint sum);
    return clamp_drive(sum / FRAC_ONE);
  endfunction

  // One side of the hold loop: integral zone, saturating integral, PID sum
  function automatic longint pid_update(
    input longint                                     err,
    inout logic signed [dpah_pkg::INTEGRAL_BITS-1:0] integ,
    inout logic signed [dpah_pkg::ERR_W-1:0]         prev
  );
    longint acc;
    longint mag;
    longint slope;
    mag = (err < 0) ? -err : err;
    if (mag < longint'(izone)) begin
      acc = longint'(integ) + err;
      if (acc > INTEG_MAX) acc = INTEG_MAX;
      else if (acc < INTEG_MIN) acc = INTEG_MIN;
    end else begin
      acc = 0;
    end
    integ = dpah_pkg::INTEGRAL_BITS'(acc);
    slope = err - longint'(prev);
    prev = dpah_pkg::ERR_W'(err);
    return scale_drive(slope * longint'(kd_gain) + acc * longint'(ki_gain)
                       + err * longint'(kp_gain));
  endfunction

  // Advance the controller by one tick and return the drives it produces
  function automatic drive_result_t predict_drive(input dpah_pkg::in_item_t req);
    drive_result_t res;
    longint pos_l;
    longint pos_r;
    longint stick;
    longint pid_l;
    longint pid_r;
    longint skew_term;
    longint left;
    longint right;
    logic manual;
    pos_l = SENSOR_MAX - longint'(req.left_raw);
    pos_r = longint'(req.right_raw);
    stick = longint'(req.stick_value);
    if (!targets_captured) begin
      hold_target_l = dpah_pkg::SENSOR_BITS'(pos_l);
      hold_target_r = dpah_pkg::SENSOR_BITS'(pos_r);
      targets_captured = 1'b1;
    end
    pid_l = pid_update(longint'(hold_target_l) - pos_l, integ_sum_l, last_err_l);
    pid_r = pid_update(longint'(hold_target_r) - pos_r, integ_sum_r, last_err_r);
    manual = 1'b1;
    if (req.func == dpah_pkg::FUNC_FULL_UP || req.func == dpah_pkg::FUNC_FULL_DOWN) begin
      skew_term = (pos_r - pos_l + longint'(skew_ofs)) * longint'(skew_k);
      if (req.func == dpah_pkg::FUNC_FULL_UP) begin
        left = scale_drive(FULL_BASE + skew_term);
        right = scale_drive(FULL_BASE - skew_term);
      end else begin
        left = scale_drive(-FULL_BASE - skew_term);
        right = scale_drive(-FULL_BASE + skew_term);
      end
    end else if (stick > longint'(deadband) || stick < -longint'(deadband)) begin
      left = clamp_drive(stick);
      right = left;
    end else begin
      left = pid_l;
      right = pid_r;
      manual = 1'b0;
    end
    // Any manual drive moves the hold point
    if (manual) begin
      hold_target_l = dpah_pkg::SENSOR_BITS'(pos_l);
      hold_target_r = dpah_pkg::SENSOR_BITS'(pos_r);
    end
    res.left_drive = dpah_pkg::DRIVE_W'(left);
    res.right_drive = dpah_pkg::DRIVE_W'(right);
    res.manual_active = manual;
    return res;
  endfunction

  function automatic dpah_pkg::in_item_t make_request(input int l, input int r,
                                                      input dpah_pkg::func_t f,
                                                      input int s);
    dpah_pkg::in_item_t req;
    req.left_raw = dpah_pkg::SENSOR_BITS'(l);
    req.right_raw = dpah_pkg::SENSOR_BITS'(r);
    req.func = f;
    req.stick_value = dpah_pkg::STICK_W'(s);
    return req;
  endfunction

  // Stick value that stays inside the deadband
  function automatic int quiet_stick();
    return int'($urandom_range(0, 2 * int'(deadband))) - int'(deadband);
  endfunction

  // Stick value beyond the deadband, either sign
  function automatic int loud_stick();
    int mag;
    mag = int'($urandom_range(int'(deadband) + 1, 128));
    if (mag == 128 || $urandom_range(0, 1) == 1) return -mag;
    return mag;
  endfunction

  function automatic dpah_pkg::func_t quiet_func();
    return ($urandom_range(0, 9) == 0) ? FUNC_UNUSED : dpah_pkg::FUNC_HOLD;
  endfunction

  function automatic int wander(input int v);
    int n;
    n = v + int'($urandom_range(0, 80)) - 40;
    if (n < 0) return 0;
    if (n > int'(SENSOR_MAX)) return int'(SENSOR_MAX);
    return n;
  endfunction

  function automatic void check_field(input string what, input longint want,
                                      input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // Offer one request after a random gap; predict it just before it is taken
  task automatic offer(input dpah_pkg::in_item_t req, input logic has_fixed,
                       input drive_result_t fixed_res);
    drive_result_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_left_raw <= req.left_raw;
    in_right_raw <= req.right_raw;
    in_func <= req.func;
    in_stick_value <= req.stick_value;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    predicted = predict_drive(req);
    expected_drives.push_back(has_fixed ? fixed_res : predicted);
    sent_count++;
    @(posedge clk);
  endtask

  // Drop valid and hold until every result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_drives.size() != 0);
  endtask

  task automatic write_register(input dpah_pkg::cfg_idx_t idx, input int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= dpah_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    case (idx)
      dpah_pkg::CFG_PROP_GAIN:      kp_gain = dpah_pkg::GAIN_W'(value);
      dpah_pkg::CFG_INTEG_GAIN:     ki_gain = dpah_pkg::GAIN_W'(value);
      dpah_pkg::CFG_DERIV_GAIN:     kd_gain = dpah_pkg::GAIN_W'(value);
      dpah_pkg::CFG_INTEGRAL_ZONE:  izone = dpah_pkg::ZONE_W'(value);
      dpah_pkg::CFG_STICK_DEADBAND: deadband = dpah_pkg::DBAND_W'(value);
      dpah_pkg::CFG_SKEW_GAIN:      skew_k = dpah_pkg::GAIN_W'(value);
      dpah_pkg::CFG_SKEW_OFFSET:    skew_ofs = dpah_pkg::OFFSET_W'(value);
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int kp, input int ki, input int kd, input int zone,
                                input int band, input int sk, input int so);
    write_register(dpah_pkg::CFG_PROP_GAIN, kp);
    write_register(dpah_pkg::CFG_INTEG_GAIN, ki);
    write_register(dpah_pkg::CFG_DERIV_GAIN, kd);
    write_register(dpah_pkg::CFG_INTEGRAL_ZONE, zone);
    write_register(dpah_pkg::CFG_STICK_DEADBAND, band);
    write_register(dpah_pkg::CFG_SKEW_GAIN, sk);
    write_register(dpah_pkg::CFG_SKEW_OFFSET, so);
    cfg_we <= 1'b0;
  endtask

  // Small position drift around the hold point
  task automatic drift_episode(input int len);
    for (int k = 0; k < len; k++) begin
      cur_l_raw = wander(cur_l_raw);
      cur_r_raw = wander(cur_r_raw);
      offer(make_request(cur_l_raw, cur_r_raw, quiet_func(), quiet_stick()), 1'b0, '0);
    end
  endtask

  // Park at an extreme with a full-speed command, then hold far from it
  task automatic far_episode(input int len);
    int ext_l;
    int ext_r;
    ext_l = ($urandom_range(0, 1) == 1) ? 0 : int'(SENSOR_MAX);
    ext_r = ($urandom_range(0, 1) == 1) ? 0 : int'(SENSOR_MAX);
    offer(make_request(ext_l, ext_r,
                       ($urandom_range(0, 1) == 1) ? dpah_pkg::FUNC_FULL_UP
                                                   : dpah_pkg::FUNC_FULL_DOWN,
                       int'($urandom_range(0, 255))), 1'b0, '0);
    for (int k = 0; k < len; k++) begin
      cur_l_raw = (ext_l == 0) ? int'(SENSOR_MAX) - int'($urandom_range(0, 100))
                               : int'($urandom_range(0, 100));
      cur_r_raw = (ext_r == 0) ? int'(SENSOR_MAX) - int'($urandom_range(0, 100))
                               : int'($urandom_range(0, 100));
      offer(make_request(cur_l_raw, cur_r_raw, quiet_func(), quiet_stick()), 1'b0, '0);
    end
  endtask

  // Short burst of full-speed or joystick commands at new positions
  task automatic manual_episode(input int len);
    int kind;
    for (int k = 0; k < len; k++) begin
      cur_l_raw = int'($urandom_range(0, 4095));
      cur_r_raw = int'($urandom_range(0, 4095));
      kind = int'($urandom_range(0, 2));
      if (kind == 0)
        offer(make_request(cur_l_raw, cur_r_raw, dpah_pkg::FUNC_FULL_UP,
                           int'($urandom_range(0, 255))), 1'b0, '0);
      else if (kind == 1)
        offer(make_request(cur_l_raw, cur_r_raw, dpah_pkg::FUNC_FULL_DOWN,
                           int'($urandom_range(0, 255))), 1'b0, '0);
      else
        offer(make_request(cur_l_raw, cur_r_raw, quiet_func(), loud_stick()), 1'b0, '0);
    end
  endtask

  // Fully random requests
  task automatic noise_episode(input int len);
    for (int k = 0; k < len; k++) begin
      cur_l_raw = int'($urandom_range(0, 4095));
      cur_r_raw = int'($urandom_range(0, 4095));
      offer(make_request(cur_l_raw, cur_r_raw, dpah_pkg::func_t'($urandom_range(0, 3)),
                         int'($urandom_range(0, 255))), 1'b0, '0);
    end
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        tx_idle_pct = 16;
        rx_idle_pct = 47;
      end
      1: begin
        tx_idle_pct = 47;
        rx_idle_pct = 16;
      end
      default: begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
    endcase
  endtask

  // Stop the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side back-pressure, with one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (stall_request) begin
        stall_request = 1'b0;
        stall_left = LONG_STALL - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Compare each result taken at the coming edge with the oldest expectation
  always @(negedge clk) begin
    drive_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_drives.size() == 0) begin
        $display("%0t: result with nothing expected, actual %0d %0d %0d", $time,
                 out_left_drive, out_right_drive, out_manual_active);
        mismatches++;
      end else begin
        want = expected_drives.pop_front();
        check_field("left_drive", want.left_drive, out_left_drive);
        check_field("right_drive", want.right_drive, out_right_drive);
        check_field("manual_active", want.manual_active, out_manual_active);
      end
    end
  end

  initial begin
    int phase_start;
    int sel;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_left_raw <= '0;
    in_right_raw <= '0;
    in_func <= dpah_pkg::FUNC_HOLD;
    in_stick_value <= '0;
    cfg_we <= 1'b0;
    cfg_index <= dpah_pkg::CFG_PROP_GAIN;
    cfg_wdata <= '0;
    set_idling(0);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed ticks under reset registers
    foreach (directed_rows[i])
      offer(directed_rows[i].req, directed_rows[i].has_fixed, directed_rows[i].fixed_res);

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_drained();
      case (phase)
        0: apply_settings(32767, 32767, 32767, 4095, 127, 32767, 4095);
        1: apply_settings(-32768, -32768, -32768, 0, 0, -32768, -4096);
        2: apply_settings(614, 40, 2000, 100, 30, 300, 0);
        3: apply_settings(-3000, 25, -800, 400, 10, -1500, -700);
        4: apply_settings(int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)),
                          int'($urandom_range(0, 65535)), int'($urandom_range(0, 4095)),
                          int'($urandom_range(0, 127)), int'($urandom_range(0, 65535)),
                          int'($urandom_range(0, 8191)));
        default: apply_settings(int'($urandom_range(0, 2000)) - 1000,
                                int'($urandom_range(0, 200)) - 100,
                                int'($urandom_range(0, 4000)) - 2000,
                                int'($urandom_range(0, 600)), int'($urandom_range(0, 60)),
                                int'($urandom_range(0, 1000)) - 500,
                                int'($urandom_range(0, 8191)));
      endcase
      set_idling(phase / 2);
      // Long result-side stall while requests keep coming
      if (phase == 4) stall_request = 1'b1;
      phase_start = sent_count;
      // Hold far from the target under the extreme settings to push the integral into saturation where the zone allows
      if (phase < 2) far_episode(160);
      while (sent_count - phase_start < PHASE_ITEMS) begin
        sel = int'($urandom_range(0, 99));
        if (sel < 40) drift_episode(int'($urandom_range(5, 40)));
        else if (sel < 50) far_episode(int'($urandom_range(20, 200)));
        else if (sel < 80) manual_episode(int'($urandom_range(1, 4)));
        else noise_episode(int'($urandom_range(1, 3)));
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
